[src/sliding_window_range_tracker_core_macros.svh]
// ---------------------------------------------------------------------------
// range tracker assertion macros
// concurrent assertion shorthands, compiled out when ASSERT_OFF is defined
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_RANGE_TRACKER_CORE_MACROS_SVH
`define SLIDING_WINDOW_RANGE_TRACKER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define SWRT_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("range tracker assertion failed");
// next-cycle implication
`define SWRT_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("range tracker assertion failed");
`else
`define SWRT_ASSERT_IMP(label, clk, rst_n, pre, post)
`define SWRT_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif

`endif

[src/swrt_pkg.sv]
// ---------------------------------------------------------------------------
// range tracker package
// shared widths, codes, sequencer states and control structs
// ---------------------------------------------------------------------------
`default_nettype none

package swrt_pkg;

  // default sizes
  localparam int DEPTH_DEF         = 256;
  localparam int RESCAN_PERIOD_DEF = 60;

  // field widths
  localparam int SAMPLE_W    = 16;
  localparam int FILL_W      = 9;
  localparam int FACTOR_W    = 17;
  localparam int MODE_W      = 2;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 17;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_FIELD_W = 6 * SAMPLE_W + FILL_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;
  localparam int ACC_W       = 34;

  // Q1.16 one
  localparam logic [FACTOR_W-1:0] ONE_Q16 = 17'h10000;

  // sample extremes and range reset values
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] RANGE_LOW_RST  = -16'sd1;
  localparam logic signed [SAMPLE_W-1:0] RANGE_HIGH_RST = 16'sd1;

  // request kinds
  localparam logic KIND_PUSH  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_HIST_LEN    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SHRINK_BACK = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SMOOTH_EN   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SMOOTH_F    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_RANGE_MODE  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_MANUAL_LOW  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_MANUAL_HIGH = 3'd6;

  // plot range modes
  localparam logic [MODE_W-1:0] RMODE_AUTO      = 2'd0;
  localparam logic [MODE_W-1:0] RMODE_MANUAL    = 2'd1;
  localparam logic [MODE_W-1:0] RMODE_LOW_FIXED = 2'd2;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_EVICT,
    ST_WRITE,
    ST_MAC_B,
    ST_MAC_C,
    ST_SCAN,
    ST_APPLY,
    ST_OUT
  } state_t;

  // compare unit control
  typedef struct packed {
    logic clr;
    logic chk;
    logic acc;
  } scan_ctrl_t;

  // multiply-accumulate control
  typedef struct packed {
    logic load;
    logic accum;
  } mac_ctrl_t;

endpackage

`default_nettype wire

[src/sliding_window_range_tracker_core.sv]
// ---------------------------------------------------------------------------
// sliding window range tracker: ring window min/max with moving average
// a clear resets the window and goes straight to the result; a push checks the
// evicted entries, writes, runs both average passes, then rescans when due,
// one window read per cycle; next request accepted the cycle after the result loads
// rst_n synchronous active low; window memory is not cleared
// ---------------------------------------------------------------------------
`default_nettype none
`include "sliding_window_range_tracker_core_macros.svh"

module sliding_window_range_tracker_core import swrt_pkg::*; #(
  parameter int DEPTH         = DEPTH_DEF,
  parameter int RESCAN_PERIOD = RESCAN_PERIOD_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] sample
  input  wire logic                  in_tuser,   // [0] kind
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [15:0] newest, [31:16] range_low, [47:32] range_high, [63:48] plot_low,
  // [79:64] plot_high, [95:80] smoothed, [104:96] fill, [111:105] zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tuser,  // [0] rescanned
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW   = $clog2(DEPTH);
  localparam int SW   = ((AW > FILL_W) ? AW : FILL_W) + 1;
  localparam int PH_W = $clog2(RESCAN_PERIOD + 1);

  // configuration registers
  logic [FILL_W-1:0]          hist_len_r;
  logic                       shrink_r;
  logic                       smooth_en_r;
  logic [FACTOR_W-1:0]        smooth_f_r;
  logic [MODE_W-1:0]          rmode_r;
  logic signed [SAMPLE_W-1:0] man_low_r;
  logic signed [SAMPLE_W-1:0] man_high_r;

  // sequencer and tracker state
  state_t                     state_r, state_nxt;
  logic                       kind_r, kind_nxt;
  logic signed [SAMPLE_W-1:0] samp_r, samp_nxt;
  logic [AW-1:0]              wp_r, wp_nxt;
  logic [AW-1:0]              rptr_r, rptr_nxt;
  logic [FILL_W-1:0]          fill_r, fill_nxt;
  logic [FILL_W-1:0]          nfill_r, nfill_nxt;
  logic [FILL_W-1:0]          cnt_r, cnt_nxt;
  logic signed [SAMPLE_W-1:0] low_r, low_nxt;
  logic signed [SAMPLE_W-1:0] high_r, high_nxt;
  logic signed [SAMPLE_W-1:0] avg_r, avg_nxt;
  logic [PH_W-1:0]            phase_r, phase_nxt;
  logic                       seen_r, seen_nxt;
  logic                       rescan_r, rescan_nxt;
  logic                       rd_vld_r;

  // result register
  logic                       out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]      out_data_r, out_data_nxt;
  logic                       out_user_r, out_user_nxt;

  // unit hookups
  logic                       ram_re;
  logic                       ram_we;
  logic [SAMPLE_W-1:0]        ram_rdata;
  scan_ctrl_t                 scan_ctrl;
  mac_ctrl_t                  mac_ctrl;
  logic                       scan_hit;
  logic signed [SAMPLE_W-1:0] scan_min;
  logic signed [SAMPLE_W-1:0] scan_max;
  logic signed [SAMPLE_W-1:0] mac_avg;

  // start-of-push helpers
  logic [FILL_W-1:0]          limit;
  logic [FILL_W:0]            fill_p1;
  logic                       evicting;
  logic [SW-1:0]              wp_ext;
  logic [SW-1:0]              fill_ext;
  logic [SW-1:0]              start_ext;
  logic [AW-1:0]              rptr_inc;
  logic [AW-1:0]              wp_inc;
  logic [PH_W-1:0]            phase_p1;
  logic signed [SAMPLE_W-1:0] plot_low;
  logic signed [SAMPLE_W-1:0] plot_high;
  logic signed [SAMPLE_W-1:0] newest;

  // configuration port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_len_r  <= FILL_W'(256);
      shrink_r    <= 1'b0;
      smooth_en_r <= 1'b0;
      smooth_f_r  <= FACTOR_W'(6554);
      rmode_r     <= RMODE_AUTO;
      man_low_r   <= RANGE_LOW_RST;
      man_high_r  <= RANGE_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        CFG_HIST_LEN:    hist_len_r  <= cfg_data[FILL_W-1:0];
        CFG_SHRINK_BACK: shrink_r    <= cfg_data[0];
        CFG_SMOOTH_EN:   smooth_en_r <= cfg_data[0];
        CFG_SMOOTH_F:    smooth_f_r  <= cfg_data[FACTOR_W-1:0];
        CFG_RANGE_MODE:  rmode_r     <= cfg_data[MODE_W-1:0];
        CFG_MANUAL_LOW:  man_low_r   <= $signed(cfg_data[SAMPLE_W-1:0]);
        CFG_MANUAL_HIGH: man_high_r  <= $signed(cfg_data[SAMPLE_W-1:0]);
        default: ;
      endcase
    end
  end

  // window size limit clamped to 1..DEPTH
  always_comb begin
    if (hist_len_r == '0) begin
      limit = FILL_W'(1);
    end else if (32'(hist_len_r) > DEPTH) begin
      limit = FILL_W'(DEPTH);
    end else begin
      limit = hist_len_r;
    end
  end

  assign fill_p1  = {1'b0, fill_r} + 1'b1;
  assign evicting = fill_p1 > {1'b0, limit};

  // oldest entry of the window
  assign wp_ext    = SW'(wp_r);
  assign fill_ext  = SW'(fill_r);
  assign start_ext = (wp_ext >= fill_ext) ? (wp_ext - fill_ext)
                                          : (wp_ext + SW'(DEPTH) - fill_ext);

  // ring pointer steps
  assign rptr_inc = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
  assign wp_inc   = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign phase_p1 = phase_r + 1'b1;

  // memory and unit control
  assign ram_re = ((state_r == ST_EVICT) || (state_r == ST_SCAN)) && (cnt_r != '0);
  assign ram_we = (state_r == ST_WRITE);

  assign scan_ctrl.clr = (state_r == ST_MAC_C);
  assign scan_ctrl.chk = (state_r == ST_EVICT) && rd_vld_r;
  assign scan_ctrl.acc = (state_r == ST_SCAN) && rd_vld_r;

  assign mac_ctrl.load  = (state_r == ST_WRITE);
  assign mac_ctrl.accum = (state_r == ST_MAC_B);

  // plot range selection
  always_comb begin
    unique case (rmode_r)
      RMODE_AUTO: begin
        plot_low  = low_r;
        plot_high = high_r;
      end
      RMODE_MANUAL: begin
        plot_low  = man_low_r;
        plot_high = man_high_r;
      end
      RMODE_LOW_FIXED: begin
        plot_low  = man_low_r;
        plot_high = high_r;
      end
      default: begin
        plot_low  = RANGE_LOW_RST;
        plot_high = RANGE_HIGH_RST;
      end
    endcase
  end

  // a push always leaves its own sample newest; a clear empties the window
  assign newest = (kind_r == KIND_CLEAR) ? '0 : samp_r;

  assign in_tready = (state_r == ST_IDLE);

  // sequencer next state and datapath
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    samp_nxt      = samp_r;
    wp_nxt        = wp_r;
    rptr_nxt      = rptr_r;
    fill_nxt      = fill_r;
    nfill_nxt     = nfill_r;
    cnt_nxt       = cnt_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    avg_nxt       = avg_r;
    phase_nxt     = phase_r;
    seen_nxt      = seen_r;
    rescan_nxt    = rescan_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          kind_nxt  = in_tuser;
          samp_nxt  = $signed(in_tdata[SAMPLE_W-1:0]);
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        rescan_nxt = 1'b0;
        if (kind_r == KIND_CLEAR) begin
          wp_nxt    = '0;
          fill_nxt  = '0;
          phase_nxt = '0;
          seen_nxt  = 1'b0;
          low_nxt   = RANGE_LOW_RST;
          high_nxt  = RANGE_HIGH_RST;
          state_nxt = ST_OUT;
        end else begin
          seen_nxt = 1'b1;
          if (!seen_r) avg_nxt = samp_r;
          if (samp_r > high_r) high_nxt = samp_r;
          if (samp_r < low_r) low_nxt = samp_r;
          rptr_nxt  = start_ext[AW-1:0];
          cnt_nxt   = evicting ? FILL_W'(fill_p1 - {1'b0, limit}) : '0;
          nfill_nxt = evicting ? limit : fill_p1[FILL_W-1:0];
          state_nxt = ST_EVICT;
        end
      end
      ST_EVICT: begin
        if (scan_hit) rescan_nxt = 1'b1;
        if (cnt_r != '0) begin
          rptr_nxt = rptr_inc;
          cnt_nxt  = cnt_r - 1'b1;
        end else begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        wp_nxt   = wp_inc;
        fill_nxt = nfill_r;
        if (phase_p1 == PH_W'(RESCAN_PERIOD)) begin
          phase_nxt  = '0;
          rescan_nxt = 1'b1;
        end else begin
          phase_nxt = phase_p1;
        end
        state_nxt = ST_MAC_B;
      end
      ST_MAC_B: begin
        state_nxt = ST_MAC_C;
      end
      ST_MAC_C: begin
        if (smooth_en_r) avg_nxt = mac_avg;
        if (rescan_r) begin
          cnt_nxt   = fill_r;
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_SCAN: begin
        if (cnt_r != '0) begin
          rptr_nxt = rptr_inc;
          cnt_nxt  = cnt_r - 1'b1;
        end else begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (shrink_r) begin
          low_nxt  = scan_min;
          high_nxt = scan_max;
        end else begin
          if (scan_min < low_r) low_nxt = scan_min;
          if (scan_max > high_r) high_nxt = scan_max;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{OUT_PAD_W{1'b0}}, fill_r, avg_r, plot_high, plot_low,
                           high_r, low_r, newest};
          out_user_nxt  = rescan_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and tracker registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      low_r       <= RANGE_LOW_RST;
      high_r      <= RANGE_HIGH_RST;
      avg_r       <= '0;
      phase_r     <= '0;
      seen_r      <= 1'b0;
      rescan_r    <= 1'b0;
      rd_vld_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      avg_r       <= avg_nxt;
      phase_r     <= phase_nxt;
      seen_r      <= seen_nxt;
      rescan_r    <= rescan_nxt;
      rd_vld_r    <= ram_re;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    samp_r     <= samp_nxt;
    rptr_r     <= rptr_nxt;
    nfill_r    <= nfill_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // window store
  swrt_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (samp_r),
    .re    (ram_re),
    .raddr (rptr_r),
    .rdata (ram_rdata)
  );

  // shared compare unit
  swrt_scan u_scan (
    .clk     (clk),
    .ctrl    (scan_ctrl),
    .rdata   ($signed(ram_rdata)),
    .low     (low_r),
    .high    (high_r),
    .hit     (scan_hit),
    .min_val (scan_min),
    .max_val (scan_max)
  );

  // shared multiplier for the moving average
  swrt_mac u_mac (
    .clk     (clk),
    .ctrl    (mac_ctrl),
    .sample  (samp_r),
    .average (avg_r),
    .factor  (smooth_f_r),
    .avg_new (mac_avg)
  );

  // checks
  `SWRT_ASSERT_IMP(a_range_order, clk, rst_n, state_r == ST_IDLE, low_r <= high_r)
  `SWRT_ASSERT_IMP(a_fill_depth, clk, rst_n, state_r == ST_IDLE, 32'(fill_r) <= DEPTH)
  `SWRT_ASSERT_NXT(a_clear_empty, clk, rst_n, state_r == ST_START && kind_r == KIND_CLEAR, fill_r == '0 && wp_r == '0)
  `SWRT_ASSERT_IMP(a_read_walk, clk, rst_n, rd_vld_r, state_r == ST_EVICT || state_r == ST_SCAN)

endmodule

`default_nettype wire

[src/swrt_ram.sv]
// ---------------------------------------------------------------------------
// window memory
// single write port, single registered read port sample store
// ---------------------------------------------------------------------------
`default_nettype none

module swrt_ram import swrt_pkg::*; #(
  parameter int  DEPTH = DEPTH_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [AW-1:0]       waddr,
  input  wire logic [SAMPLE_W-1:0] wdata,
  input  wire logic                re,
  input  wire logic [AW-1:0]       raddr,
  output logic      [SAMPLE_W-1:0] rdata
);

  logic [SAMPLE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/swrt_scan.sv]
// ---------------------------------------------------------------------------
// window compare unit
// eviction hit test and running min/max over rescanned entries
// ---------------------------------------------------------------------------
`default_nettype none

module swrt_scan import swrt_pkg::*; (
  input  wire logic                       clk,
  input  wire scan_ctrl_t                 ctrl,
  input  wire logic signed [SAMPLE_W-1:0] rdata,
  input  wire logic signed [SAMPLE_W-1:0] low,
  input  wire logic signed [SAMPLE_W-1:0] high,
  output logic                            hit,
  output logic signed [SAMPLE_W-1:0]      min_val,
  output logic signed [SAMPLE_W-1:0]      max_val
);

  logic signed [SAMPLE_W-1:0] min_r, min_nxt;
  logic signed [SAMPLE_W-1:0] max_r, max_nxt;

  // evicted sample at or beyond an extreme
  assign hit = ctrl.chk && ((rdata <= low) || (rdata >= high));

  // min/max accumulate
  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    if (ctrl.clr) begin
      min_nxt = SAMPLE_MAX;
      max_nxt = SAMPLE_MIN;
    end else if (ctrl.acc) begin
      if (rdata < min_r) min_nxt = rdata;
      if (rdata > max_r) max_nxt = rdata;
    end
  end

  always_ff @(posedge clk) begin
    min_r <= min_nxt;
    max_r <= max_nxt;
  end

  assign min_val = min_r;
  assign max_val = max_r;

endmodule

`default_nettype wire

[src/swrt_mac.sv]
// ---------------------------------------------------------------------------
// moving average unit
// one shared multiplier, two passes: sample*f then average*(1-f)
// ---------------------------------------------------------------------------
`default_nettype none

module swrt_mac import swrt_pkg::*; (
  input  wire logic                       clk,
  input  wire mac_ctrl_t                  ctrl,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic signed [SAMPLE_W-1:0] average,
  input  wire logic        [FACTOR_W-1:0] factor,
  output logic signed [SAMPLE_W-1:0]      avg_new
);

  logic        [FACTOR_W-1:0]   f_sat;
  logic signed [SAMPLE_W-1:0]   op_a;
  logic signed [FACTOR_W:0]     op_b;
  logic signed [ACC_W-1:0]      prod;
  logic signed [ACC_W-1:0]      acc_r, acc_nxt;
  logic signed [ACC_W-1:0]      rnd;

  // weight saturates at one
  assign f_sat = (factor > ONE_Q16) ? ONE_Q16 : factor;

  // operand select for the shared multiplier
  assign op_a = ctrl.accum ? average : sample;
  assign op_b = ctrl.accum ? $signed({1'b0, ONE_Q16 - f_sat}) : $signed({1'b0, f_sat});
  assign prod = op_a * op_b;

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.load) begin
      acc_nxt = prod;
    end else if (ctrl.accum) begin
      acc_nxt = acc_r + prod;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // round to nearest, ties toward plus infinity
  assign rnd     = acc_r + ACC_W'(32768);
  assign avg_new = rnd[SAMPLE_W+15:16];

endmodule

`default_nettype wire
